@@ sv/fdo_pkg.sv @@
// ----------------------------------------------------------------------------
// fdo_pkg
// Shared types, constants and helper functions for the odometry block.
// ----------------------------------------------------------------------------
package fdo_pkg;

  // cordic and angle resolution
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int STEP_W       = 5;
  localparam logic signed [35:0] INV_GAIN_Q30 = 36'sd652032875;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 2'd1;
  localparam logic [23:0] TICK_ANGLE_RESET   = 24'd26675;
  localparam logic [15:0] WHEEL_RADIUS_RESET = 16'd4915;

  // divider length: one quotient bit per cycle over a 33-bit dividend
  localparam int DIV_BITS = 33;

  // one classified input item
  typedef struct packed {
    logic signed [16:0] tick_sum;
    logic [23:0]        interval;
    logic               zero_interval;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } item_t;

  // back-end sequencer
  typedef enum logic [3:0] {
    B_IDLE, B_MUL1, B_MUL2, B_MUL3, B_VINIT, B_VEC, B_YAW, B_RINIT,
    B_ROT, B_FLIP, B_MX, B_MY, B_UPD, B_DIV, B_OUT
  } back_state_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680862;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41721;
      5'd15:   v = 32'd20860;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2607;
      5'd19:   v = 32'd1303;
      5'd20:   v = 32'd651;
      5'd21:   v = 32'd325;
      5'd22:   v = 32'd162;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // signed quotient from magnitude and sign, saturated to 32 bits
  function automatic logic signed [31:0] sat_quot(input logic [32:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (q > 33'h080000000) r = 32'sh80000000;
      else r = 32'(-q);
    end else begin
      if (q > 33'h07FFFFFFF) r = 32'sh7FFFFFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/diff_drive_odometry_imu_yaw.sv @@
// ----------------------------------------------------------------------------
// diff_drive_odometry_imu_yaw
// Differential-drive dead reckoning with yaw from an orientation quaternion.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  left_ticks right_ticks interval quat_w..z
//   out      out_valid/out_stall  pos_x pos_y heading linear/angular_velocity
//                                 zero_interval
//   cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// Each item passes through the back end in turn: two 16-step cordic passes and
// a bit-serial divider, run twice unless the interval is zero.
// A two-entry queue takes new items while the back end is busy.
// rst is synchronous: pose, yaw history and config return to reset values.
// A stalled result holds in the output register; the back end waits on it.
// ----------------------------------------------------------------------------
module diff_drive_odometry_imu_yaw (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            left_ticks,
  input  logic signed [15:0]            right_ticks,
  input  logic [23:0]                   interval,
  input  logic signed [15:0]            quat_w,
  input  logic signed [15:0]            quat_x,
  input  logic signed [15:0]            quat_y,
  input  logic signed [15:0]            quat_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            pos_x,
  output logic signed [31:0]            pos_y,
  output logic [15:0]                   heading,
  output logic signed [31:0]            linear_velocity,
  output logic signed [31:0]            angular_velocity,
  output logic                          zero_interval,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                   cfg_data
);

  logic [23:0]    tick_angle;
  logic [15:0]    wheel_radius;
  logic           q_valid;
  logic           q_take;
  fdo_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_angle   <= fdo_pkg::TICK_ANGLE_RESET;
      wheel_radius <= fdo_pkg::WHEEL_RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdo_pkg::CFG_TICK_ANGLE:   tick_angle <= cfg_data;
        fdo_pkg::CFG_WHEEL_RADIUS: wheel_radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input side and queue
  fdo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_ticks  (left_ticks),
    .right_ticks (right_ticks),
    .interval    (interval),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take)
  );

  // execution side
  fdo_back u_back (
    .clk              (clk),
    .rst              (rst),
    .tick_angle       (tick_angle),
    .wheel_radius     (wheel_radius),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_take           (q_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .heading          (heading),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .zero_interval    (zero_interval)
  );

endmodule

@@ sv/fdo_front.sv @@
// ----------------------------------------------------------------------------
// fdo_front
// Input side: takes transactions, forms the tick sum and the zero-interval
// flag, and holds items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fdo_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_ticks,
  input  logic signed [15:0] right_ticks,
  input  logic [23:0]        interval,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               q_valid,
  output fdo_pkg::item_t     q_item,
  input  logic               q_take
);

  fdo_pkg::item_t entry [2];
  fdo_pkg::item_t new_item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           pop;

  // classify the incoming item
  always_comb begin
    new_item.tick_sum      = {left_ticks[15], left_ticks} + {right_ticks[15], right_ticks};
    new_item.interval      = interval;
    new_item.zero_interval = (interval == 24'd0);
    new_item.qw            = quat_w;
    new_item.qx            = quat_x;
    new_item.qy            = quat_y;
    new_item.qz            = quat_z;
  end

  assign in_stall = count[1];
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = entry[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) entry[wr_ptr] <= new_item;
  end

endmodule

@@ sv/fdo_back.sv @@
// ----------------------------------------------------------------------------
// fdo_back
// Execution side: distance products, yaw by vectoring cordic, midpoint
// rotation cordic, pose update, serial divider for both velocities and the
// result register.
// ----------------------------------------------------------------------------
module fdo_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [23:0]        tick_angle,
  input  logic [15:0]        wheel_radius,
  input  logic               q_valid,
  input  fdo_pkg::item_t     q_item,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity,
  output logic               zero_interval
);

  localparam int AB = fdo_pkg::ANGLE_BITS;

  fdo_pkg::back_state_t state, state_next;

  fdo_pkg::item_t             item;
  logic [39:0]                tr;
  logic signed [31:0]         m1;
  logic signed [31:0]         m2;
  logic signed [57:0]         prod;
  logic signed [32:0]         num;
  logic signed [33:0]         den;
  logic signed [32:0]         ds;
  logic signed [35:0]         cx;
  logic signed [35:0]         cy;
  logic [31:0]                cz;
  logic [fdo_pkg::STEP_W-1:0] step;
  logic                       degen;
  logic                       flip;
  logic [AB-1:0]              yaw;
  logic signed [AB-1:0]       delta;
  logic [AB-1:0]              mid;
  logic signed [33:0]         cosv;
  logic signed [33:0]         sinv;
  logic signed [66:0]         pm;
  logic [31:0]                x_position;
  logic [31:0]                y_position;
  logic [AB-1:0]              heading_angle;
  logic [AB-1:0]              previous_yaw;
  logic [32:0]                dvd;
  logic [23:0]                rem;
  logic [5:0]                 cnt;
  logic                       sel;
  logic                       neg;
  logic signed [31:0]         lv;
  logic signed [31:0]         av;
  logic                       out_load;

  logic [31:0]        atan_v;
  logic signed [35:0] sx;
  logic signed [35:0] sy;
  logic [31:0]        z_r;
  logic [AB-1:0]      yaw_new;
  logic [31:0]        a_ang;
  logic signed [66:0] pm_r;
  logic [24:0]        rem_sh;
  logic [25:0]        diff;
  logic               ge;
  logic [32:0]        dvd_next;
  logic               last_step;
  logic               div_last;
  logic [31:0]        h32;
  logic signed [AB-1:0] delta_new;
  logic signed [AB-1:0] delta_half;
  logic [AB:0]        delta_mag;
  logic [32:0]        av_mag;

  // shared datapath helpers
  always_comb begin
    atan_v    = fdo_pkg::atan_turn(step);
    sx        = cx >>> step;
    sy        = cy >>> step;
    z_r       = cz + (32'd1 << (31 - AB));
    yaw_new   = degen ? '0 : z_r[31 -: AB];
    delta_new = yaw_new - previous_yaw;
    a_ang     = {mid, {(32 - AB){1'b0}}};
    pm_r      = pm + (67'sd1 <<< 29);
    rem_sh    = {rem, dvd[32]};
    diff      = {1'b0, rem_sh} - {2'b00, item.interval};
    ge        = !diff[25];
    dvd_next  = {dvd[31:0], ge};
    last_step = (step == fdo_pkg::STEP_W'(fdo_pkg::CORDIC_STEPS - 1));
    div_last  = (cnt == 6'(fdo_pkg::DIV_BITS - 1));
    h32       = {heading_angle, {(32 - AB){1'b0}}};
    delta_half = delta_new >>> 1;
    delta_mag = delta[AB-1] ? -{delta[AB-1], delta} : {1'b0, delta};
    av_mag    = {delta_mag, {(32 - AB){1'b0}}};
    out_load  = !out_valid || !out_stall;
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= fdo_pkg::B_IDLE;
    else state <= state_next;
  end

  // next state and queue handshake
  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    case (state)
      fdo_pkg::B_IDLE: begin
        q_take = 1'b1;
        if (q_valid) state_next = fdo_pkg::B_MUL1;
      end
      fdo_pkg::B_MUL1:  state_next = fdo_pkg::B_MUL2;
      fdo_pkg::B_MUL2:  state_next = fdo_pkg::B_MUL3;
      fdo_pkg::B_MUL3:  state_next = fdo_pkg::B_VINIT;
      fdo_pkg::B_VINIT: state_next = fdo_pkg::B_VEC;
      fdo_pkg::B_VEC:   if (last_step) state_next = fdo_pkg::B_YAW;
      fdo_pkg::B_YAW:   state_next = fdo_pkg::B_RINIT;
      fdo_pkg::B_RINIT: state_next = fdo_pkg::B_ROT;
      fdo_pkg::B_ROT:   if (last_step) state_next = fdo_pkg::B_FLIP;
      fdo_pkg::B_FLIP:  state_next = fdo_pkg::B_MX;
      fdo_pkg::B_MX:    state_next = fdo_pkg::B_MY;
      fdo_pkg::B_MY:    state_next = fdo_pkg::B_UPD;
      fdo_pkg::B_UPD:   state_next = item.zero_interval ? fdo_pkg::B_OUT : fdo_pkg::B_DIV;
      fdo_pkg::B_DIV:   if (div_last && sel) state_next = fdo_pkg::B_OUT;
      fdo_pkg::B_OUT:   if (out_load) state_next = fdo_pkg::B_IDLE;
      default:          state_next = fdo_pkg::B_IDLE;
    endcase
  end

  // pose state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      previous_yaw  <= '0;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        fdo_pkg::B_MY: x_position <= x_position + pm_r[61:30];
        fdo_pkg::B_UPD: begin
          y_position    <= y_position + pm_r[61:30];
          heading_angle <= heading_angle + delta;
          previous_yaw  <= yaw;
        end
        default: ;
      endcase
      if (state == fdo_pkg::B_OUT && out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      fdo_pkg::B_IDLE: item <= q_item;
      fdo_pkg::B_MUL1: begin
        tr <= tick_angle * wheel_radius;
        m1 <= item.qx * item.qy;
        m2 <= item.qw * item.qz;
      end
      fdo_pkg::B_MUL2: begin
        prod <= item.tick_sum * $signed({1'b0, tr});
        num  <= {m1[31], m1} + {m2[31], m2};
        m1   <= item.qy * item.qy;
        m2   <= item.qz * item.qz;
      end
      fdo_pkg::B_MUL3: begin
        ds  <= 33'((prod + (58'sd1 <<< 24)) >>> 25);
        den <= 34'sd134217728 - 34'(m1) - 34'(m2);
      end
      fdo_pkg::B_VINIT: begin
        degen <= (num == 33'sd0) && (den == 34'sd0);
        step  <= '0;
        if (den[33]) begin
          cx <= -36'(den);
          cy <= -36'(num);
          cz <= 32'h80000000;
        end else begin
          cx <= 36'(den);
          cy <= 36'(num);
          cz <= 32'd0;
        end
      end
      fdo_pkg::B_VEC: begin
        step <= step + 1'b1;
        if (!cy[35]) begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + atan_v;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - atan_v;
        end
      end
      fdo_pkg::B_YAW: begin
        yaw   <= yaw_new;
        delta <= delta_new;
      end
      fdo_pkg::B_RINIT: begin
        cx   <= fdo_pkg::INV_GAIN_Q30;
        cy   <= '0;
        step <= '0;
      end
      fdo_pkg::B_ROT: begin
        step <= step + 1'b1;
        if (!cz[31]) begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - atan_v;
        end else begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + atan_v;
        end
      end
      fdo_pkg::B_FLIP: begin
        cosv <= flip ? -34'(cx) : 34'(cx);
        sinv <= flip ? -34'(cy) : 34'(cy);
      end
      fdo_pkg::B_MX: pm <= ds * cosv;
      fdo_pkg::B_MY: pm <= ds * sinv;
      fdo_pkg::B_UPD: begin
        lv  <= '0;
        av  <= '0;
        sel <= 1'b0;
        neg <= ds[32];
        dvd <= 33'(ds[32] ? -ds : ds);
        rem <= '0;
        cnt <= '0;
      end
      fdo_pkg::B_DIV: begin
        dvd <= dvd_next;
        rem <= ge ? diff[23:0] : rem_sh[23:0];
        cnt <= cnt + 1'b1;
        if (div_last) begin
          if (!sel) lv <= fdo_pkg::sat_quot(dvd_next, neg);
          else av <= fdo_pkg::sat_quot(dvd_next, neg);
          sel <= 1'b1;
          neg <= delta[AB-1];
          dvd <= av_mag;
          rem <= '0;
          cnt <= '0;
        end
      end
      default: ;
    endcase
    // midpoint heading and rotation fold, set up between yaw and rotation
    if (state == fdo_pkg::B_YAW) begin
      mid <= heading_angle + delta_half;
    end
    if (state == fdo_pkg::B_RINIT) begin
      flip <= a_ang[31] ^ a_ang[30];
      cz   <= (a_ang[31] ^ a_ang[30]) ? {~a_ang[31], a_ang[30:0]} : a_ang;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == fdo_pkg::B_OUT && out_load) begin
      pos_x            <= x_position;
      pos_y            <= y_position;
      heading          <= h32[31:16];
      linear_velocity  <= lv;
      angular_velocity <= av;
      zero_interval    <= item.zero_interval;
    end
  end

endmodule

@@ tb/tb_diff_drive_odometry_imu_yaw.sv @@
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_imu_yaw
// Self-checking bench for the odometry block: wheel ticks and quaternions go
// in with random gaps, results come out under random stall, and each result
// is compared with a fixed-point pose estimate held in the bench.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_imu_yaw;

  // out-of-range register indexes, ignored by the block
  localparam logic [fdo_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [fdo_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int PHASE_ITEMS  = 300;
  localparam int SETTLE_CYC   = 300;

  localparam logic [31:0] ATAN_LUT [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41721, 32'd20860};

  typedef struct {
    logic signed [15:0] lt, rt;
    logic [23:0]        ivl;
    logic signed [15:0] qw, qx, qy, qz;
  } wheel_sample_t;

  typedef struct {
    logic [31:0] px, py;
    logic [15:0] hd;
    logic [31:0] lv, av;
    logic        zi;
  } pose_t;

  typedef struct {
    wheel_sample_t smp;
    bit            typed;
    pose_t         want;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic signed [15:0] left_ticks, right_ticks, quat_w, quat_x, quat_y, quat_z;
  logic [23:0] interval;
  logic out_valid, out_stall;
  logic signed [31:0] pos_x, pos_y, linear_velocity, angular_velocity;
  logic [15:0] heading;
  logic zero_interval;
  logic cfg_valid, cfg_ready;
  logic [fdo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [23:0] cfg_data;

  // bench copy of block state and registers
  logic [23:0] est_tick;
  logic [15:0] est_radius;
  logic [31:0] est_x, est_y;
  logic [15:0] est_heading, est_prev_yaw;

  pose_t pose_fifo [$];
  int    errors;
  bit    quiet;
  int    stall_left;

  diff_drive_odometry_imu_yaw u_dut (.*);

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // yaw from quaternion terms by vectoring cordic
  function automatic logic [15:0] yaw_of(longint num, longint den);
    longint x, y, t;
    logic [31:0] z;
    x = den; y = num; z = 0;
    if (num == 0 && den == 0) return 16'd0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + ATAN_LUT[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - ATAN_LUT[i];
      end
    end
    z = z + 32'h00008000;
    return z[31:16];
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // advance the estimated pose by one sample
  function automatic pose_t advance_pose(wheel_sample_t s);
    pose_t r;
    longint ds, num, den, dl, c, sn, x, y, t, z, lv, av;
    logic [31:0] a;
    logic [15:0] yaw, d, mid;
    bit flip;
    ds = (longint'(s.lt) + longint'(s.rt)) * longint'(est_tick) * longint'(est_radius);
    ds = (ds + (64'sd1 <<< 24)) >>> 25;
    num = longint'(s.qx) * longint'(s.qy) + longint'(s.qw) * longint'(s.qz);
    den = (64'sd1 <<< 27) - longint'(s.qy) * longint'(s.qy) - longint'(s.qz) * longint'(s.qz);
    yaw = yaw_of(num, den);
    d = yaw - est_prev_yaw;
    dl = longint'($signed(d));
    mid = est_heading + 16'(dl >>> 1);
    // cosine and sine of the midpoint heading
    a = {mid, 16'h0000};
    flip = 0;
    if (a >= 32'h40000000 && a < 32'hC0000000) begin
      a = a - 32'h80000000; flip = 1;
    end
    z = longint'($signed(a));
    x = 64'sd652032875; y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - longint'(ATAN_LUT[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + longint'(ATAN_LUT[i]);
      end
    end
    c = flip ? -x : x;
    sn = flip ? -y : y;
    est_x = est_x + 32'((ds * c + (64'sd1 <<< 29)) >>> 30);
    est_y = est_y + 32'((ds * sn + (64'sd1 <<< 29)) >>> 30);
    est_heading = est_heading + 16'(dl);
    est_prev_yaw = yaw;
    lv = 0; av = 0;
    if (s.ivl != 0) begin
      lv = clip32(ds / longint'(s.ivl));
      av = clip32((dl * 65536) / longint'(s.ivl));
    end
    r.px = est_x; r.py = est_y; r.hd = est_heading;
    r.lv = 32'(lv); r.av = 32'(av); r.zi = (s.ivl == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: stall draw and compare
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      int n;
      pose_t w;
      if (pose_fifo.size() == 0) begin
        $display("%0t: result with nothing expected, actual x %h y %h", $time, pos_x, pos_y);
        errors++;
      end else begin
        w = pose_fifo.pop_front();
        check_field("pos_x", w.px, pos_x);
        check_field("pos_y", w.py, pos_y);
        check_field("heading", {16'h0, w.hd}, {16'h0, heading});
        check_field("linear_velocity", w.lv, linear_velocity);
        check_field("angular_velocity", w.av, angular_velocity);
        check_field("zero_interval", {31'h0, w.zi}, {31'h0, zero_interval});
      end
      n = quiet ? 0 : $urandom_range(0, 9);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // one input transaction, valid held across back-to-back samples
  task automatic send_sample(wheel_sample_t s, bit typed, pose_t want);
    int gap;
    pose_t p;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    left_ticks <= s.lt; right_ticks <= s.rt; interval <= s.ivl;
    quat_w <= s.qw; quat_x <= s.qx; quat_y <= s.qy; quat_z <= s.qz;
    do @(posedge clk); while (in_stall);
    p = advance_pose(s);
    pose_fifo.push_back(typed ? want : p);
  endtask

  task automatic write_reg(logic [fdo_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == fdo_pkg::CFG_TICK_ANGLE) est_tick = val;
    else if (idx == fdo_pkg::CFG_WHEEL_RADIUS) est_radius = val[15:0];
  endtask

  // wait for all results, then let the back end settle
  task automatic drain();
    in_valid <= 0;
    while (pose_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic wheel_sample_t random_sample();
    wheel_sample_t s;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      s.lt = 16'($signed($urandom_range(0, 400)) - 200);
      s.rt = 16'($signed($urandom_range(0, 400)) - 200);
    end else if (k < 9) begin
      s.lt = 16'($urandom); s.rt = 16'($urandom);
    end else begin
      s.lt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      s.rt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end
    k = $urandom_range(0, 9);
    if (k == 0) s.ivl = '0;
    else if (k < 3) s.ivl = 24'($urandom_range(1, 16));
    else if (k < 6) s.ivl = 24'($urandom_range(1, 5000));
    else s.ivl = 24'($urandom);
    k = $urandom_range(0, 9);
    if (k == 0) begin
      // degenerate quaternion, both atan2 terms zero
      s.qw = 16'sd0; s.qx = 16'sd0; s.qy = 16'sd8192; s.qz = 16'sd8192;
    end else if (k < 4) begin
      // yaw-only rotation with random angle
      s.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
      s.qz = 16'($signed($urandom_range(0, 32768)) - 16384);
      s.qx = 16'sd0; s.qy = 16'sd0;
    end else begin
      s.qw = 16'($urandom); s.qx = 16'($urandom);
      s.qy = 16'($urandom); s.qz = 16'($urandom);
    end
    return s;
  endfunction

  function automatic wheel_sample_t mk(int lt, int rt, int ivl, int qw, int qx, int qy, int qz);
    wheel_sample_t s;
    s.lt = 16'(lt); s.rt = 16'(rt); s.ivl = 24'(ivl);
    s.qw = 16'(qw); s.qx = 16'(qx); s.qy = 16'(qy); s.qz = 16'(qz);
    return s;
  endfunction

  // stimulus
  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    pose_t zero_pose;
    logic [23:0] tick_set [5];
    logic [15:0] rad_set [5];
    errors = 0; quiet = 0;
    rst <= 1;
    in_valid <= 0; left_ticks <= 0; right_ticks <= 0; interval <= 0;
    quat_w <= 0; quat_x <= 0; quat_y <= 0; quat_z <= 0;
    cfg_valid <= 0; cfg_index <= 0; cfg_data <= 0;
    est_tick = fdo_pkg::TICK_ANGLE_RESET; est_radius = fdo_pkg::WHEEL_RADIUS_RESET;
    est_x = 0; est_y = 0; est_heading = 0; est_prev_yaw = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    repeat (SETTLE_CYC) @(posedge clk);

    // directed rows: the first two, with degenerate quaternion and no travel, give a zero pose
    zero_pose = '{px: 0, py: 0, hd: 0, lv: 0, av: 0, zi: 1};
    row.typed = 1; row.want = zero_pose;
    row.smp = mk(0, 0, 0, 0, 0, 8192, 8192);       rows.push_back(row);
    row.want.zi = 0;
    row.smp = mk(0, 0, 1, 0, 0, 8192, 8192);       rows.push_back(row);
    row.typed = 0;
    row.smp = mk(100, 100, 10, 16384, 0, 0, 0);    rows.push_back(row);
    row.smp = mk(32767, 32767, 1, 16384, 0, 0, 0); rows.push_back(row);
    row.smp = mk(-32768, -32768, 1, 0, 0, 0, 16384); rows.push_back(row);
    row.smp = mk(32767, -32768, 16777215, 11585, 0, 0, 11585); rows.push_back(row);
    row.smp = mk(-32768, 32767, 0, 11585, 0, 0, -11585); rows.push_back(row);
    // yaw jump across the half turn
    row.smp = mk(500, 300, 1, 100, 0, 0, 16384);   rows.push_back(row);
    row.smp = mk(500, 300, 1, 100, 0, 0, -16384);  rows.push_back(row);
    row.smp = mk(1, 1, 1, -16384, 0, 0, 100);      rows.push_back(row);
    row.smp = mk(0, 0, 2, -32768, -32768, -32768, -32768); rows.push_back(row);
    row.smp = mk(7, -3, 3, 32767, 32767, 32767, 32767); rows.push_back(row);
    row.smp = mk(200, 200, 16777215, -32768, 32767, -32768, 32767); rows.push_back(row);
    row.smp = mk(-1, 0, 1, 0, 16384, 16384, 0);    rows.push_back(row);
    row.smp = mk(32767, 32767, 16777215, 0, 0, 0, 0); rows.push_back(row);
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].typed, rows[i].want);
    drain();

    // register settings, extremes included
    tick_set = '{24'hFFFFFF, 24'd0, fdo_pkg::TICK_ANGLE_RESET, 24'd1, 24'h000000};
    rad_set  = '{16'hFFFF, 16'd0, fdo_pkg::WHEEL_RADIUS_RESET, 16'd1, 16'h0000};
    tick_set[4] = 24'($urandom); rad_set[4] = 16'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_reg(fdo_pkg::CFG_TICK_ANGLE, tick_set[ph]);
        write_reg(fdo_pkg::CFG_WHEEL_RADIUS, {8'h00, rad_set[ph]});
      end else begin
        write_reg(fdo_pkg::CFG_TICK_ANGLE, 24'($urandom));
        write_reg(fdo_pkg::CFG_WHEEL_RADIUS, 24'($urandom));
      end
      write_reg(ph[0] ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pose_t none;
        none = zero_pose;
        if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_sample(random_sample(), 0, none);
      end
      quiet = 0;
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/fdo_pkg.sv
sv/fdo_front.sv
sv/fdo_back.sv
sv/diff_drive_odometry_imu_yaw.sv
tb/tb_diff_drive_odometry_imu_yaw.sv
